// File: design/qsa_pkg.sv
// shared types, constants and transition decode for the quadrature step accumulator
package qsa_pkg;

  // held direction codes
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_e;

  // pin pair is {a, b}; both pins high when the knob rests
  localparam logic [1:0] PinPairReset = 2'b11;
  localparam logic [7:0] TargetStepsReset = 8'd4;

  // event handed from the step logic to the result buffer
  typedef struct packed {
    logic valid;
    logic right;
  } evt_t;

  // classify one old-to-new pin transition
  function automatic dir_e step_dir(input logic [1:0] old_pair, input logic [1:0] new_pair);
    dir_e dir;
    unique case ({old_pair, new_pair})
      4'b00_01: dir = DIR_RIGHT;
      4'b00_10: dir = DIR_LEFT;
      4'b01_00: dir = DIR_LEFT;
      4'b01_11: dir = DIR_RIGHT;
      4'b10_00: dir = DIR_RIGHT;
      4'b10_11: dir = DIR_LEFT;
      4'b11_01: dir = DIR_LEFT;
      4'b11_10: dir = DIR_RIGHT;
      default:  dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

// File: design/qsa_step.sv
// pin pair tracking, direction hold and step counting
module qsa_step import qsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic       pin_a_i,
  input  logic       pin_b_i,
  input  logic [7:0] target_steps_i,
  output evt_t       evt_o
);

  logic [1:0] pin_pair_q, pin_pair_d;
  dir_e       held_q, held_d;
  logic [7:0] count_q, count_d;

  logic [1:0] now_pair;
  dir_e       dir;
  logic [7:0] count_next;
  logic       held_valid;

  // decode the sampled transition
  assign now_pair   = {pin_a_i, pin_b_i};
  assign dir        = step_dir(pin_pair_q, now_pair);
  assign held_valid = (held_q == DIR_LEFT) || (held_q == DIR_RIGHT);
  assign count_next = (dir == held_q) ? count_q + 8'd1 : 8'd1;

  // next state and event
  always_comb begin
    pin_pair_d  = pin_pair_q;
    held_d      = held_q;
    count_d     = count_q;
    evt_o.valid = 1'b0;
    evt_o.right = (dir == DIR_RIGHT);
    if (take_i && (now_pair != pin_pair_q)) begin
      pin_pair_d = now_pair;
      if (dir != DIR_NONE) begin
        held_d = dir;
        if (!held_valid) begin
          count_d = 8'd1;
        end else if (count_next >= target_steps_i) begin
          count_d     = 8'd0;
          evt_o.valid = 1'b1;
        end else begin
          count_d = count_next;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_pair_q <= PinPairReset;
      held_q     <= DIR_NONE;
      count_q    <= 8'd0;
    end else begin
      pin_pair_q <= pin_pair_d;
      held_q     <= held_d;
      count_q    <= count_d;
    end
  end

  // an event always clears the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |=> (count_q == 8'd0))
    else $error("count not cleared after event");

  // no count builds up before a direction is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == DIR_NONE) |-> (count_q == 8'd0))
    else $error("count set without a held direction");

endmodule

// File: design/qsa_out_buf.sv
// result register with one skid entry
module qsa_out_buf import qsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  evt_t evt_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic turn_direction_o
);

  logic out_valid_q, out_valid_d;
  logic out_dir_q, out_dir_d;
  logic skid_valid_q, skid_valid_d;
  logic skid_dir_q, skid_dir_d;
  logic take;

  assign take = out_valid_q && !out_stall_i;

  // fill and drain
  always_comb begin
    out_valid_d  = out_valid_q;
    out_dir_d    = out_dir_q;
    skid_valid_d = skid_valid_q;
    skid_dir_d   = skid_dir_q;
    if (skid_valid_q) begin
      if (take) begin
        out_dir_d    = skid_dir_q;
        skid_valid_d = 1'b0;
      end
    end else if (evt_i.valid) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_dir_d   = evt_i.right;
      end else begin
        skid_valid_d = 1'b1;
        skid_dir_d   = evt_i.right;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_dir_q  <= out_dir_d;
    skid_dir_q <= skid_dir_d;
  end

  assign full_o           = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign turn_direction_o = out_dir_q;

  // skid entry only holds when the result register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a request while output is empty");

  // skid fills only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled result");

endmodule

// File: design/quadrature_step_accumulator.sv
// top level of the quadrature step accumulator
//
// Input channel: one request per sample of the two encoder pins (pin_a_i,
// pin_b_i), taken when in_valid_i is high and in_stall_o is low. A sample
// equal to the previous one does nothing; a valid quadrature transition
// counts one step in its direction, a reversal restarts the count at 1.
// The first valid step after reset only records the direction.
// Output channel: when the count reaches target_steps, one request carrying
// turn_direction_o (0 left, 1 right) is offered on out_valid_o and taken when
// out_stall_i is low.
// Configuration: target_steps is written by cfg_we_i with cfg_wdata_i; the
// user must write it only while the block is idle; the block does not check.
// Reset value is 4. Results go into the result register or the skid entry.
// Throughput: one sample per cycle while in_stall_o is low; decode and count
// update are a single level of logic between the state registers.
// When the receiver stalls, the result register holds and one more result
// fits in a skid entry; in_stall_o rises only while that entry is occupied.
// Reset (rst_ni low, asynchronous) sets the pins to both high, clears the
// held direction, the count and both result entries.
module quadrature_step_accumulator import qsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       pin_a_i,
  input  logic       pin_b_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       turn_direction_o
);

  logic [7:0] target_q;
  logic       take;
  logic       full;
  evt_t       evt;

  // target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetStepsReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  // step decode and counting
  qsa_step u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .pin_a_i        (pin_a_i),
    .pin_b_i        (pin_b_i),
    .target_steps_i (target_q),
    .evt_o          (evt)
  );

  // result buffering
  qsa_out_buf u_out_buf (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_i            (evt),
    .full_o           (full),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .turn_direction_o (turn_direction_o)
  );

endmodule

// File: tb/quadrature_step_accumulator_tb.sv
// self-checking testbench for the quadrature step accumulator
module quadrature_step_accumulator_tb import qsa_pkg::*;;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic TURN_LEFT = 1'b0;
  localparam logic TURN_RIGHT = 1'b1;

  // kinds of rows in the directed script
  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_e;

  // how a directed sample is checked: by the predictor or by a fixed outcome
  typedef enum logic [1:0] {
    OUT_MODEL,
    OUT_NONE,
    OUT_LEFT,
    OUT_RIGHT
  } outcome_e;

  typedef struct {
    row_e       kind;
    logic [7:0] value;
    logic [1:0] pair;
    outcome_e   outcome;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       pin_a = 1'b1;
  logic       pin_b = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       turn_dir;

  // knob predictor state
  logic [1:0] knob_pair = PinPairReset;
  dir_e       knob_dir = DIR_NONE;
  logic [7:0] knob_count = 8'd0;
  logic [7:0] knob_target = TargetStepsReset;

  logic       turns_due[$];
  logic       turn_due;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  bit         idle_on = 1'b1;
  bit         spin_right = 1'b0;
  row_t       script [26];

  quadrature_step_accumulator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pin_a_i         (pin_a),
    .pin_b_i         (pin_b),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .turn_direction_o(turn_dir)
  );

  always #5 clk = ~clk;

  // one detent position clockwise (right) and counterclockwise (left)
  function automatic logic [1:0] cw(input logic [1:0] pair);
    case (pair)
      2'b11:   return 2'b10;
      2'b10:   return 2'b00;
      2'b00:   return 2'b01;
      default: return 2'b11;
    endcase
  endfunction

  function automatic logic [1:0] ccw(input logic [1:0] pair);
    case (pair)
      2'b11:   return 2'b01;
      2'b01:   return 2'b00;
      2'b00:   return 2'b10;
      default: return 2'b11;
    endcase
  endfunction

  // advance the predicted knob state by one accepted sample
  function automatic void turn_knob(input logic [1:0] now, output bit fired,
                                    output logic right);
    dir_e dir;
    fired = 1'b0;
    right = TURN_LEFT;
    if (now == knob_pair) return;
    if (now == cw(knob_pair)) dir = DIR_RIGHT;
    else if (now == ccw(knob_pair)) dir = DIR_LEFT;
    else dir = DIR_NONE;
    knob_pair = now;
    if (dir == DIR_NONE) return;
    // first step after reset only records the direction
    if (knob_dir == DIR_NONE) begin
      knob_dir = dir;
      knob_count = 8'd1;
      return;
    end
    if (dir == knob_dir) begin
      knob_count = knob_count + 8'd1;
    end else begin
      knob_dir = dir;
      knob_count = 8'd1;
    end
    if (knob_count >= knob_target) begin
      knob_count = 8'd0;
      fired = 1'b1;
      right = (dir == DIR_RIGHT) ? TURN_RIGHT : TURN_LEFT;
    end
  endfunction

  // offer one pin sample, wait for it to be taken, record what it should cause
  task automatic send_sample(input logic [1:0] pair, input outcome_e outcome);
    bit   fired;
    logic right;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pin_a <= pair[1];
    pin_b <= pair[0];
    do @(posedge clk); while (in_stall);
    turn_knob(pair, fired, right);
    case (outcome)
      OUT_MODEL: if (fired) turns_due.push_back(right);
      OUT_RIGHT: turns_due.push_back(TURN_RIGHT);
      OUT_LEFT:  turns_due.push_back(TURN_LEFT);
      default:   ;
    endcase
  endtask

  // stop offering samples and let every pending result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (turns_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [7:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    knob_target = value;
  endtask

  // mostly steady rotation with reversals, repeats and diagonal jumps
  task automatic spin_phase(input int count, input int reverse_pct, input int wild_pct);
    logic [1:0] pick;
    int         r;
    repeat (count) begin
      if ($urandom_range(0, 99) < reverse_pct) spin_right = !spin_right;
      r = $urandom_range(0, 99);
      if (r < wild_pct) pick = 2'($urandom_range(0, 3));
      else if (r < 70) pick = spin_right ? cw(knob_pair) : ccw(knob_pair);
      else if (r < 85) pick = knob_pair;
      else pick = ~knob_pair;
      send_sample(pick, OUT_MODEL);
    end
  endtask

  // receiver stall bursts; out_stall drops again before each new burst
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= (hold_left != 0);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(1, 3);
      out_stall <= 1'b1;
    end
  end

  // compare each taken result with the oldest expected turn
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (turns_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual turn_direction %0d",
                 $time, turn_dir);
        errors++;
      end else begin
        turn_due = turns_due.pop_front();
        if (turn_dir !== turn_due) begin
          $display("%0t: turn_direction mismatch, expected %0d, actual %0d",
                   $time, turn_due, turn_dir);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake or register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // directed script, starting from the reset target of four
    script = '{
      '{ROW_SAMPLE, 8'd0,   2'b11, OUT_NONE},   // same as the resting pair
      '{ROW_SAMPLE, 8'd0,   2'b10, OUT_NONE},   // first step only records
      '{ROW_SAMPLE, 8'd0,   2'b00, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b01, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b11, OUT_RIGHT},  // fourth right step
      '{ROW_SAMPLE, 8'd0,   2'b01, OUT_MODEL},  // reversal restarts at one
      '{ROW_SAMPLE, 8'd0,   2'b00, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b10, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b11, OUT_LEFT},
      '{ROW_SAMPLE, 8'd0,   2'b00, OUT_NONE},   // diagonal jumps change nothing
      '{ROW_SAMPLE, 8'd0,   2'b11, OUT_NONE},
      '{ROW_SAMPLE, 8'd0,   2'b10, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b01, OUT_NONE},
      '{ROW_SAMPLE, 8'd0,   2'b10, OUT_NONE},
      '{ROW_SAMPLE, 8'd0,   2'b00, OUT_MODEL},
      '{ROW_WRITE,  8'd2,   2'b00, OUT_MODEL},  // target lowered to the count
      '{ROW_SAMPLE, 8'd0,   2'b01, OUT_MODEL},
      '{ROW_WRITE,  8'd0,   2'b00, OUT_MODEL},  // zero target fires on every step
      '{ROW_SAMPLE, 8'd0,   2'b00, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b10, OUT_MODEL},
      '{ROW_WRITE,  8'd1,   2'b00, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b00, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b10, OUT_MODEL},
      '{ROW_WRITE,  8'd255, 2'b00, OUT_MODEL},  // widest target
      '{ROW_SAMPLE, 8'd0,   2'b11, OUT_MODEL},
      '{ROW_SAMPLE, 8'd0,   2'b01, OUT_MODEL}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) write_target(script[i].value);
      else send_sample(script[i].pair, script[i].outcome);
    end

    // keep turning left until the count reaches the widest target
    spin_right = 1'b0;
    spin_phase(450, 0, 0);

    // random phases under a range of targets, the last one without idling
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       write_target(8'd1);
        1:       write_target(8'd4);
        2:       write_target(8'd0);
        3:       write_target(8'd3);
        4:       write_target(8'($urandom_range(2, 16)));
        5:       write_target(8'($urandom_range(1, 255)));
        6:       write_target(8'd2);
        default: write_target(8'd5);
      endcase
      if (p == 7) idle_on = 1'b0;
      spin_phase(135, 10, 6);
    end

    settle();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/qsa_pkg.sv
design/qsa_step.sv
design/qsa_out_buf.sv
design/quadrature_step_accumulator.sv
tb/quadrature_step_accumulator_tb.sv
